// ===== rtl/es2cal_pkg.sv =====
// Package for the epoch-seconds to calendar unit.
// Holds the sequencer state type, calendar constants and the month length table.
// No dependencies.
package es2cal_pkg;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DDAY  = 7'b0000010,
    ST_DSEC  = 7'b0000100,
    ST_DMIN  = 7'b0001000,
    ST_YEAR  = 7'b0010000,
    ST_MONTH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  localparam logic [11:0] EpochYear    = 12'd1970;
  localparam logic [11:0] LastYear     = 12'd2100;
  localparam logic [11:0] FallbackYear = 12'd2026;

  localparam logic [16:0] SecPerDay = 17'd86400;
  localparam logic [16:0] SecPerMin = 17'd60;

  // Days from 1970-01-01 through 2100-12-31 (131 years, 32 of them leap)
  localparam logic [15:0] DaysToEnd = 16'd47847;

  localparam logic [8:0] LeapYearLen   = 9'd366;
  localparam logic [8:0] CommonYearLen = 9'd365;

  localparam logic [3:0] MonthFeb  = 4'd1;
  localparam logic [3:0] MonthLast = 4'd11;

  // Divider step counts (radix 4): 64-bit dividend, 18-bit and 12-bit slots
  localparam logic [4:0] DayDivSteps = 5'd31;
  localparam logic [4:0] SecDivSteps = 5'd8;
  localparam logic [4:0] MinDivSteps = 5'd5;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [11:0] year;
  } result_t;

  // Gregorian rule, reduced for years 1970..2100: 2000 is leap, 2100 is not
  function automatic logic is_leap(input logic [11:0] year);
    is_leap = (year[1:0] == 2'b00) && (year != LastYear);
  endfunction

  // Days in a month, February stretched in a leap year
  function automatic logic [8:0] month_len(input logic [3:0] month, input logic leap);
    logic [8:0] len;
    unique case (month)
      4'd0:    len = 9'd31;
      4'd1:    len = leap ? 9'd29 : 9'd28;
      4'd2:    len = 9'd31;
      4'd3:    len = 9'd30;
      4'd4:    len = 9'd31;
      4'd5:    len = 9'd30;
      4'd6:    len = 9'd31;
      4'd7:    len = 9'd31;
      4'd8:    len = 9'd30;
      4'd9:    len = 9'd31;
      4'd10:   len = 9'd30;
      4'd11:   len = 9'd31;
      default: len = 9'd31;
    endcase
    month_len = len;
  endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// Epoch seconds to UTC calendar date and time, iterative implementation.
// Depends on es2cal_pkg (state type, constants, month table).
//
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | timestamp_i (64b signed)
// out     | output    | out_valid_o/out_stall_i | hour/minute/second/day/month/year
//
// From acceptance to a valid result, one transaction takes 32 radix-4 steps of the
// shared divider for days and 9 + 6 steps for seconds and minutes; the day subtractor
// then walks the years past 1970 (up to 130) and the months (up to 11), each walk
// ending in a fitting step, and a last step finishes. A date past 2100 skips the
// year walk. Finishing waits while a previous result is stalled in the output register.
// in_stall_o is high from acceptance until the result moves to the output register.
// The output register holds a result under out_stall_i while a new item is worked on.
// Reset (rst_ni low, asynchronous) returns to idle with no result pending.
module epoch_seconds_to_calendar_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [63:0] timestamp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         hour_o,
  output logic [5:0]         minute_o,
  output logic [5:0]         second_o,
  output logic [4:0]         day_o,
  output logic [3:0]         month_o,
  output logic [11:0]        year_o
);

  es2cal_pkg::state_e state_q, state_d;

  // Shared divider registers
  logic [63:0] acc_q, acc_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] dsr_q, dsr_d;
  logic [4:0]  cnt_q, cnt_d;

  // Calendar registers
  logic [15:0] days_q, days_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic        big_q, big_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  es2cal_pkg::result_t   res_q, res_d;

  // Radix-4 restoring divider step
  logic [18:0] part_rem;
  logic [18:0] dsr1, dsr2, dsr3;
  logic [18:0] step_rem;
  logic [1:0]  step_digit;
  logic [63:0] step_acc;
  logic [16:0] step_rem_n;

  assign part_rem = {rem_q, acc_q[63:62]};
  assign dsr1     = {2'b00, dsr_q};
  assign dsr2     = {1'b0, dsr_q, 1'b0};
  assign dsr3     = dsr1 + dsr2;

  always_comb begin
    priority if (part_rem >= dsr3) begin
      step_digit = 2'd3;
      step_rem   = part_rem - dsr3;
    end else if (part_rem >= dsr2) begin
      step_digit = 2'd2;
      step_rem   = part_rem - dsr2;
    end else if (part_rem >= dsr1) begin
      step_digit = 2'd1;
      step_rem   = part_rem - dsr1;
    end else begin
      step_digit = 2'd0;
      step_rem   = part_rem;
    end
  end

  assign step_rem_n = step_rem[16:0];
  assign step_acc   = {acc_q[61:0], step_digit};

  // Day subtractor, shared by the year and month walks
  logic        leap;
  logic [8:0]  unit_len;
  logic [16:0] day_diff;
  logic        day_fits;

  assign leap     = es2cal_pkg::is_leap(year_q);
  assign unit_len = (state_q == es2cal_pkg::ST_YEAR)
                    ? (leap ? es2cal_pkg::LeapYearLen : es2cal_pkg::CommonYearLen)
                    : es2cal_pkg::month_len(month_q, leap);
  assign day_diff = {1'b0, days_q} - {8'd0, unit_len};
  assign day_fits = day_diff[16];

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    cnt_d       = cnt_q;
    days_d      = days_q;
    year_d      = year_q;
    month_d     = month_q;
    big_d       = big_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    second_d    = second_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      es2cal_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          // Clamp a negative timestamp to zero
          acc_d   = timestamp_i[63] ? 64'd0 : timestamp_i;
          rem_d   = 17'd0;
          dsr_d   = es2cal_pkg::SecPerDay;
          cnt_d   = es2cal_pkg::DayDivSteps;
          state_d = es2cal_pkg::ST_DDAY;
        end
      end

      es2cal_pkg::ST_DDAY: begin
        acc_d = step_acc;
        rem_d = step_rem_n;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          // Quotient is the day count; remainder is the second of day
          days_d  = step_acc[15:0];
          big_d   = (|step_acc[63:16]) || (step_acc[15:0] >= es2cal_pkg::DaysToEnd);
          acc_d   = {1'b0, step_rem_n, 46'd0};
          rem_d   = 17'd0;
          dsr_d   = es2cal_pkg::SecPerMin;
          cnt_d   = es2cal_pkg::SecDivSteps;
          state_d = es2cal_pkg::ST_DSEC;
        end
      end

      es2cal_pkg::ST_DSEC: begin
        acc_d = step_acc;
        rem_d = step_rem_n;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          // Minute of day is below 1440, fits an 11-bit slot
          second_d = step_rem_n[5:0];
          acc_d    = {1'b0, step_acc[10:0], 52'd0};
          rem_d    = 17'd0;
          cnt_d    = es2cal_pkg::MinDivSteps;
          state_d  = es2cal_pkg::ST_DMIN;
        end
      end

      es2cal_pkg::ST_DMIN: begin
        acc_d = step_acc;
        rem_d = step_rem_n;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          minute_d = step_rem_n[5:0];
          hour_d   = step_acc[4:0];
          month_d  = 4'd0;
          if (big_q) begin
            // Past the end of 2100: substitute 1 January 2026
            year_d  = es2cal_pkg::FallbackYear;
            days_d  = 16'd0;
            state_d = es2cal_pkg::ST_MONTH;
          end else begin
            year_d  = es2cal_pkg::EpochYear;
            state_d = es2cal_pkg::ST_YEAR;
          end
        end
      end

      es2cal_pkg::ST_YEAR: begin
        if (day_fits) begin
          state_d = es2cal_pkg::ST_MONTH;
        end else begin
          days_d = day_diff[15:0];
          year_d = year_q + 12'd1;
        end
      end

      es2cal_pkg::ST_MONTH: begin
        if (day_fits || month_q == es2cal_pkg::MonthLast) begin
          state_d = es2cal_pkg::ST_DONE;
        end else begin
          days_d  = day_diff[15:0];
          month_d = month_q + 4'd1;
        end
      end

      es2cal_pkg::ST_DONE: begin
        // Hand over to the output register when it is free
        if (out_free) begin
          res_d.hour   = hour_q;
          res_d.minute = minute_q;
          res_d.second = second_q;
          res_d.day    = days_q[4:0] + 5'd1;
          res_d.month  = month_q;
          res_d.year   = year_q;
          out_valid_d  = 1'b1;
          state_d      = es2cal_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = es2cal_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= es2cal_pkg::ST_IDLE;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    dsr_q    <= dsr_d;
    days_q   <= days_d;
    year_q   <= year_d;
    month_q  <= month_d;
    big_q    <= big_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    res_q    <= res_d;
  end

  assign in_stall_o  = (state_q != es2cal_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hour_o      = res_q.hour;
  assign minute_o    = res_q.minute;
  assign second_o    = res_q.second;
  assign day_o       = res_q.day;
  assign month_o     = res_q.month;
  assign year_o      = res_q.year;

endmodule

// ===== rtl/es2cal_checker.sv =====
// Port-level checks for the epoch-seconds to calendar unit, bound to the top level.
// Depends on epoch_seconds_to_calendar_unit ports only.
module es2cal_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [4:0]         hour_o,
  input logic [5:0]         minute_o,
  input logic [5:0]         second_o,
  input logic [4:0]         day_o,
  input logic [3:0]         month_o,
  input logic [11:0]        year_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hour_o) && $stable(minute_o)
      && $stable(second_o) && $stable(day_o) && $stable(month_o) && $stable(year_o))
    else $error("stalled result changed");

  // An accepted transaction keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting a transaction");

  // Time of day and month fields stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60
      && month_o < 4'd12 && day_o != 5'd0)
    else $error("result field out of range");

  // Year stays within the supported span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> year_o >= 12'd1970 && year_o <= 12'd2100)
    else $error("result year out of range");

endmodule

bind epoch_seconds_to_calendar_unit es2cal_port_checker u_es2cal_port_checker (.*);

// ===== sim/es2cal_checker.sv =====
// Checker for the epoch-seconds to calendar unit: watches both channels,
// predicts the UTC date and time of each accepted timestamp and compares.
// Depends on es2cal_pkg (result_t, year constants).
module es2cal_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic signed [63:0] timestamp_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [4:0]         hour_o,
  input  logic [5:0]         minute_o,
  input  logic [5:0]         second_o,
  input  logic [4:0]         day_o,
  input  logic [3:0]         month_o,
  input  logic [11:0]        year_o,
  output int                 fail_count_o,
  output int                 pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0]         stamp;
    es2cal_pkg::result_t date;
  } dated_stamp_t;

  dated_stamp_t expected_dates[$];
  int           mismatches = 0;

  initial begin
    fail_count_o    = 0;
    pending_count_o = 0;
  end

  // Full Gregorian rule, not the reduced one
  function automatic logic gregorian_leap(input logic [11:0] year);
    gregorian_leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
  endfunction

  function automatic logic [8:0] days_in_month(input logic [3:0] month, input logic leap);
    case (month)
      4'd1:                      days_in_month = leap ? 9'd29 : 9'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   days_in_month = 9'd30;
      default:                   days_in_month = 9'd31;
    endcase
  endfunction

  // Split seconds into time of day, then walk years and months off the day count
  function automatic es2cal_pkg::result_t to_calendar(input logic [63:0] stamp);
    logic [63:0]         secs;
    logic [63:0]         days;
    logic [11:0]         year;
    logic [8:0]          year_len;
    logic [8:0]          mon_len;
    logic                done;
    es2cal_pkg::result_t date;
    secs        = stamp[63] ? 64'd0 : stamp;
    date.second = 6'(secs % 60);
    secs        = secs / 60;
    date.minute = 6'(secs % 60);
    secs        = secs / 60;
    date.hour   = 5'(secs % 24);
    days        = secs / 24;
    year        = es2cal_pkg::EpochYear;
    done        = 1'b0;
    while (!done) begin
      year_len = gregorian_leap(year) ? 9'd366 : 9'd365;
      if (days < year_len) begin
        done = 1'b1;
      end else begin
        days = days - year_len;
        year = year + 12'd1;
        if (year > es2cal_pkg::LastYear) begin
          year = es2cal_pkg::FallbackYear;
          days = 64'd0;
          done = 1'b1;
        end
      end
    end
    date.month = 4'd0;
    done       = 1'b0;
    for (int m = 0; m < 12; m++) begin
      if (!done) begin
        mon_len = days_in_month(4'(m), gregorian_leap(year));
        if (days < mon_len) begin
          date.month = 4'(m);
          done       = 1'b1;
        end else begin
          days = days - mon_len;
        end
      end
    end
    date.day  = 5'(days + 1);
    date.year = year;
    return date;
  endfunction

  // Queue a prediction per input transaction, retire one per output transaction
  always @(posedge clk_i) begin
    dated_stamp_t        want;
    es2cal_pkg::result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want.stamp = timestamp_i;
        want.date  = to_calendar(timestamp_i);
        expected_dates.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{hour: hour_o, minute: minute_o, second: second_o,
                day: day_o, month: month_o, year: year_o};
        if (expected_dates.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("[%0t] unexpected result %0d:%0d:%0d day %0d month %0d year %0d",
                     $realtime, got.hour, got.minute, got.second, got.day, got.month,
                     got.year);
        end else begin
          want = expected_dates.pop_front();
          if (got.hour !== want.date.hour || got.minute !== want.date.minute ||
              got.second !== want.date.second || got.day !== want.date.day ||
              got.month !== want.date.month || got.year !== want.date.year) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("[%0t] timestamp %0d: expected %0d:%0d:%0d %0d/%0d/%0d,",
                       $realtime, $signed(want.stamp),
                       want.date.hour, want.date.minute, want.date.second,
                       want.date.day, want.date.month, want.date.year,
                       " got %0d:%0d:%0d %0d/%0d/%0d",
                       got.hour, got.minute, got.second, got.day, got.month, got.year);
          end
        end
      end
      fail_count_o    <= mismatches;
      pending_count_o <= expected_dates.size();
    end
  end

endmodule

// ===== sim/tb_epoch_seconds_to_calendar_unit.sv =====
// Testbench top for epoch_seconds_to_calendar_unit: drives timestamps and the
// output stall, runs a watchdog and prints the verdict.
// Depends on es2cal_pkg, the unit itself and es2cal_checker.
module tb_epoch_seconds_to_calendar_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseItems    = 250;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 250;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [63:0] timestamp_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [4:0]         hour_o;
  logic [5:0]         minute_o;
  logic [5:0]         second_o;
  logic [4:0]         day_o;
  logic [3:0]         month_o;
  logic [11:0]        year_o;
  int                 fail_count;
  int                 pending_count;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;

  epoch_seconds_to_calendar_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .timestamp_i (timestamp_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hour_o      (hour_o),
    .minute_o    (minute_o),
    .second_o    (second_o),
    .day_o       (day_o),
    .month_o     (month_o),
    .year_o      (year_o)
  );

  es2cal_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .timestamp_i     (timestamp_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .day_o           (day_o),
    .month_o         (month_o),
    .year_o          (year_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  always #6 clk_i = ~clk_i;

  // Stall the result channel at the current phase's rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Seconds at midnight of a given date; month is zero-based
  function automatic logic [63:0] date_seconds(input int year, input int month, input int day);
    longint days;
    int     leap;
    days = day - 1;
    for (int y = 1970; y < year; y++)
      days += ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 366 : 365;
    leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    for (int m = 0; m < month; m++) begin
      case (m)
        1:          days += leap ? 29 : 28;
        3, 5, 8, 10: days += 30;
        default:    days += 31;
      endcase
    end
    return 64'(days) * 64'd86400;
  endfunction

  // Present one timestamp, with an optional gap, and hold it until accepted
  task automatic send_timestamp(input logic [63:0] stamp);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    timestamp_i <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Mostly dates up to 2100, many at year and month edges, some clamped or past the range
  function automatic logic [63:0] random_timestamp();
    logic [63:0] stamp;
    int          kind;
    kind = $urandom_range(99);
    if (kind < 45) begin
      stamp = 64'($urandom_range(47847)) * 64'd86400 + 64'($urandom_range(86399));
    end else if (kind < 75) begin
      stamp = date_seconds($urandom_range(2101, 1970), $urandom_range(11), 1);
      case ($urandom_range(3))
        0:       stamp = stamp - 64'd1;
        1:       stamp = stamp + 64'($urandom_range(59));
        2:       stamp = stamp - 64'd86400 + 64'($urandom_range(86399));
        default: stamp = stamp + 64'($urandom_range(86399));
      endcase
    end else if (kind < 87) begin
      stamp = {$urandom, $urandom};
    end else if (kind < 94) begin
      stamp = -64'($urandom_range(100000000, 1));
    end else begin
      stamp = date_seconds(2101, 0, 1) + {24'd0, 8'($urandom), $urandom};
    end
    return stamp;
  endfunction

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    timestamp_i = '0;
    out_stall_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, clamping, leap days, the last valid second, fallback
    send_timestamp(64'd0);
    send_timestamp(64'd1);
    send_timestamp(-64'd1);
    send_timestamp(-64'd86400);
    send_timestamp(64'h8000_0000_0000_0000);
    send_timestamp(64'h7FFF_FFFF_FFFF_FFFF);
    send_timestamp(64'd59);
    send_timestamp(64'd3599);
    send_timestamp(64'd86399);
    send_timestamp(64'd86400);
    send_timestamp(date_seconds(1970, 11, 31) + 64'd86399);
    send_timestamp(date_seconds(1972, 1, 29) + 64'd43200);
    send_timestamp(date_seconds(1972, 2, 1) - 64'd1);
    send_timestamp(date_seconds(1999, 11, 31) + 64'd86399);
    send_timestamp(date_seconds(2000, 1, 29));
    send_timestamp(date_seconds(2026, 0, 1));
    send_timestamp(date_seconds(2100, 1, 28) + 64'd86399);
    send_timestamp(date_seconds(2100, 2, 1));
    send_timestamp(date_seconds(2100, 11, 31) + 64'd86399);
    send_timestamp(date_seconds(2101, 0, 1));
    send_timestamp(date_seconds(2101, 0, 1) + 64'd47262);
    send_timestamp((64'd1 << 40) + 64'd12345);

    // Random: free flow, slow sender, slow receiver, light idling on both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 7;  stall_pct = 7;  end
      endcase
      for (int n = 0; n < PhaseItems; n++) send_timestamp(random_timestamp());
    end
    in_valid_i <= 1'b0;

    // Let the last transaction reach the count, drain results, then let the unit settle
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
